### hw/rtl/tma_pkg.sv
// tma_pkg: widths, payload structs and control structs of the three-axis moving average
// no dependencies; used by the interfaces and by every module of the block
`timescale 1ns / 1ps

package tma_pkg;

	localparam int SampleW   = 8;
	localparam int GainW     = 5;
	localparam int FillW     = 4;
	localparam int DefWindow = 10;

	localparam logic [GainW-1:0] GainReset = GainW'(1);

	typedef logic signed [SampleW-1:0] smp_t;

	localparam smp_t SatPos = 8'sh7f;
	localparam smp_t SatNeg = 8'sh80;

	typedef struct packed {
		smp_t sample_x;
		smp_t sample_y;
		smp_t sample_z;
	} sample_t;

	typedef struct packed {
		smp_t             avg_x;
		smp_t             avg_y;
		smp_t             avg_z;
		logic [FillW-1:0] fill_count;
	} result_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic update;
	} win_ctl_t;

endpackage

### hw/rtl/tma_if.sv
// tma channel interfaces: sample input, result output and gain write channel
// depends on tma_pkg for the payload types
`timescale 1ns / 1ps

interface tma_sample_if;
	logic              valid;
	logic              ready;
	tma_pkg::sample_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tma_result_if;
	logic              valid;
	logic              ready;
	tma_pkg::result_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tma_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tma_pkg::GainW-1:0]   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/tma_window.sv
// tma_window: sample ring memory, running sums per axis, fill count and write slot
// depends on tma_pkg; driven by the sequencer in the top level
`timescale 1ns / 1ps

module tma_window #(
	parameter int WINDOW = tma_pkg::DefWindow,
	localparam int SUM_W = tma_pkg::SampleW + $clog2(WINDOW),
	localparam int CNT_W = $clog2(WINDOW + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tma_pkg::win_ctl_t       ctl,
	input  tma_pkg::sample_t        sample,
	output logic signed [SUM_W-1:0] sum_x,
	output logic signed [SUM_W-1:0] sum_y,
	output logic signed [SUM_W-1:0] sum_z,
	output logic [CNT_W-1:0]        count
);

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int EXT_W  = SUM_W - tma_pkg::SampleW;
	localparam logic [CNT_W-1:0]  FullCnt  = CNT_W'(WINDOW);
	localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(WINDOW - 1);

	tma_pkg::sample_t ring_q [WINDOW];
	tma_pkg::sample_t new_q;
	tma_pkg::sample_t old_q;

	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [CNT_W-1:0]        count_q;
	logic [SLOT_W-1:0]       slot_q;
	logic                    full;
	logic signed [SUM_W-1:0] add_x, add_y, add_z;
	logic signed [SUM_W-1:0] drop_x, drop_y, drop_z;

	assign full = (count_q == FullCnt);

	assign add_x  = {{EXT_W{new_q.sample_x[tma_pkg::SampleW-1]}}, new_q.sample_x};
	assign add_y  = {{EXT_W{new_q.sample_y[tma_pkg::SampleW-1]}}, new_q.sample_y};
	assign add_z  = {{EXT_W{new_q.sample_z[tma_pkg::SampleW-1]}}, new_q.sample_z};
	assign drop_x = full ? {{EXT_W{old_q.sample_x[tma_pkg::SampleW-1]}}, old_q.sample_x} : '0;
	assign drop_y = full ? {{EXT_W{old_q.sample_y[tma_pkg::SampleW-1]}}, old_q.sample_y} : '0;
	assign drop_z = full ? {{EXT_W{old_q.sample_z[tma_pkg::SampleW-1]}}, old_q.sample_z} : '0;

	// ring memory and sample holding registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			new_q <= sample;
		end
		if (ctl.read) begin
			old_q <= ring_q[slot_q];
		end
		if (ctl.update) begin
			ring_q[slot_q] <= new_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			count_q <= '0;
			slot_q  <= '0;
		end else if (ctl.update) begin
			sum_x_q <= sum_x_q + add_x - drop_x;
			sum_y_q <= sum_y_q + add_y - drop_y;
			sum_z_q <= sum_z_q + add_z - drop_z;
			if (!full) begin
				count_q <= count_q + CNT_W'(1);
			end
			slot_q <= (slot_q == LastSlot) ? '0 : slot_q + SLOT_W'(1);
		end
	end

	assign sum_x = sum_x_q;
	assign sum_y = sum_y_q;
	assign sum_z = sum_z_q;
	assign count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCnt)
		else $error("fill count above window");

	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> CNT_W'(slot_q) == count_q)
		else $error("write slot out of step with fill count");

	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.update && full |=> count_q == FullCnt)
		else $error("full window lost its count");

endmodule

### hw/rtl/tma_axis.sv
// tma_axis: one axis of the average, bit-serial divide of the sum by the fill count,
// then bit-serial multiply by the gain and saturation to 8 bits; depends on tma_pkg
`timescale 1ns / 1ps

module tma_axis #(
	parameter int WINDOW = tma_pkg::DefWindow,
	localparam int SUM_W = tma_pkg::SampleW + $clog2(WINDOW),
	localparam int CNT_W = $clog2(WINDOW + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [SUM_W-1:0]   sum,
	input  logic [CNT_W-1:0]          count,
	input  logic [tma_pkg::GainW-1:0] gain,
	output logic                      done,
	output tma_pkg::smp_t             avg
);

	localparam int STEP_W = $clog2(SUM_W);
	localparam int PROD_W = tma_pkg::SampleW + tma_pkg::GainW;
	localparam int SW     = tma_pkg::SampleW;
	localparam logic [PROD_W-1:0] Lim = PROD_W'(2 ** (SW - 1));

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_MUL  = 3'b100
	} axis_state_t;

	axis_state_t                state_q;
	logic [STEP_W-1:0]          step_q;
	logic [SUM_W-1:0]           dvd_q;
	logic [CNT_W-1:0]           rem_q;
	logic                       neg_q;
	logic [PROD_W-1:0]          mcand_q;
	logic [tma_pkg::GainW-1:0]  mplier_q;
	logic [PROD_W-1:0]          acc_q;
	logic                       done_q;

	logic [SUM_W-1:0] mag;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             fits;
	logic [SUM_W-1:0] dvd_next;

	assign mag      = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
	assign trial    = {rem_q, dvd_q[SUM_W-1]};
	assign fits     = (trial >= {1'b0, count});
	assign diff     = trial - {1'b0, count};
	assign dvd_next = {dvd_q[SUM_W-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			dvd_q    <= '0;
			rem_q    <= '0;
			neg_q    <= 1'b0;
			mcand_q  <= '0;
			mplier_q <= '0;
			acc_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						dvd_q    <= mag;
						rem_q    <= '0;
						neg_q    <= sum[SUM_W-1];
						mplier_q <= gain;
						step_q   <= STEP_W'(SUM_W - 1);
						done_q   <= 1'b0;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					dvd_q <= dvd_next;
					rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
					if (step_q == '0) begin
						// quotient magnitude never exceeds 128
						mcand_q <= PROD_W'(dvd_next[SW-1:0]);
						acc_q   <= '0;
						step_q  <= STEP_W'(tma_pkg::GainW - 1);
						state_q <= S_MUL;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				S_MUL: begin
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					step_q   <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// saturate the signed product to 8 bits
	always_comb begin
		if (neg_q) begin
			avg = (acc_q >= Lim) ? tma_pkg::SatNeg
				: tma_pkg::smp_t'(~acc_q[SW-1:0] + 1'b1);
		end else begin
			avg = (acc_q >= Lim) ? tma_pkg::SatPos : tma_pkg::smp_t'(acc_q[SW-1:0]);
		end
	end

	assign done = done_q;

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> count != '0)
		else $error("divide started with empty window");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < count)
		else $error("partial remainder not below divisor");

	a_done_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(state_q) == S_MUL)
		else $error("done raised outside multiply phase");

endmodule

### hw/rtl/three_axis_moving_average_top.sv
// three_axis_moving_average_top: moving average over the last WINDOW samples per axis
// channels: samples (sink) takes sample_x, sample_y, sample_z as one transfer;
//   results (source) gives avg_x, avg_y, avg_z and fill_count, one transfer per sample;
//   cfg (sink) writes the 5-bit gain, always ready, taken by the axis units when they start
// each axis result is the window sum divided by the fill count, truncated toward
//   zero, times gain, saturated to -128..127; fill_count counts up to WINDOW
// processing: after the sample transfer the sequencer passes read, update and start,
//   then the bit-serial divider gives one quotient bit a cycle, followed by a shift-add
//   gain multiply, three axes side by side; the result loads once all three are done
//   and the output register is free; no new sample is taken before that load
// reset: sums, fill count, write slot and result valid clear, gain returns to one;
//   the ring memory is not cleared, old entries are only used once rewritten
// stall: a finished result waits in the output register; the next sample is taken
//   and processed meanwhile and its result holds in the axis units until the
//   output register frees up
// depends on tma_pkg, tma_if, tma_window, tma_axis
`timescale 1ns / 1ps

module three_axis_moving_average_top #(
	parameter int WINDOW = tma_pkg::DefWindow
) (
	input logic         clk,
	input logic         arst_n,
	tma_sample_if.sink  samples,
	tma_result_if.source results,
	tma_cfg_if.sink     cfg
);

	localparam int SUM_W = tma_pkg::SampleW + $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_READ   = 5'b00010,
		S_UPDATE = 5'b00100,
		S_START  = 5'b01000,
		S_CALC   = 5'b10000
	} seq_state_t;

	seq_state_t                state_q;
	logic [tma_pkg::GainW-1:0] gain_q;
	logic                      res_valid_q;
	tma_pkg::result_t          res_q;

	tma_pkg::win_ctl_t       ctl;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
	logic [CNT_W-1:0]        count;
	logic                    start;
	logic                    done_x, done_y, done_z;
	tma_pkg::smp_t           avg_x, avg_y, avg_z;
	logic                    out_free;
	logic                    load;

	assign samples.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;

	assign ctl.capture = samples.valid && samples.ready;
	assign ctl.read    = (state_q == S_READ);
	assign ctl.update  = (state_q == S_UPDATE);
	assign start       = (state_q == S_START);

	assign out_free = !res_valid_q || results.ready;
	assign load     = (state_q == S_CALC) && done_x && done_y && done_z && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.capture) begin
						state_q <= S_READ;
					end
				end
				S_READ:   state_q <= S_UPDATE;
				S_UPDATE: state_q <= S_START;
				S_START:  state_q <= S_CALC;
				S_CALC: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= tma_pkg::GainReset;
		end else if (cfg.valid && cfg.ready) begin
			gain_q <= cfg.data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.avg_x      <= avg_x;
			res_q.avg_y      <= avg_y;
			res_q.avg_z      <= avg_z;
			res_q.fill_count <= tma_pkg::FillW'(count);
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	tma_window #(.WINDOW(WINDOW)) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (samples.data),
		.sum_x  (sum_x),
		.sum_y  (sum_y),
		.sum_z  (sum_z),
		.count  (count)
	);

	tma_axis #(.WINDOW(WINDOW)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sum    (sum_x),
		.count  (count),
		.gain   (gain_q),
		.done   (done_x),
		.avg    (avg_x)
	);

	tma_axis #(.WINDOW(WINDOW)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sum    (sum_y),
		.count  (count),
		.gain   (gain_q),
		.done   (done_y),
		.avg    (avg_y)
	);

	tma_axis #(.WINDOW(WINDOW)) u_axis_z (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sum    (sum_z),
		.count  (count),
		.gain   (gain_q),
		.done   (done_z),
		.avg    (avg_z)
	);

endmodule
